### hw/rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// shared widths, operation codes, controller commands and status for the
// rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int unsigned OPERAND_WIDTH = 16;
  localparam int unsigned MAG_W         = 2 * OPERAND_WIDTH;
  localparam int unsigned NUM_W         = 33;
  localparam int unsigned DEN_W         = 32;
  localparam int unsigned CNT_W         = $clog2(MAG_W + 1);

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_MUL_P,
    CMD_MUL_Q,
    CMD_MUL_D,
    CMD_SUM,
    CMD_GCD_INIT,
    CMD_GCD_STEP,
    CMD_DIV_NUM,
    CMD_DIV_DEN,
    CMD_TAKE_DEN,
    CMD_OUT_LOAD
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_Q,
    ST_MUL_D,
    ST_SUM,
    ST_GCD_INIT,
    ST_GCD,
    ST_DIV_NUM,
    ST_DIV_DEN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic den_zero;
    logic gcd_done;
    logic div_done;
  } dp_status_t;

endpackage

### hw/rtl/rau_in_if.sv
// ----------------------------------------------------------------------------
// rau_in_if
// input channel: operation and two signed fractions
// ----------------------------------------------------------------------------
interface rau_in_if;
  import rau_pkg::*;

  logic                            valid;
  logic                            ready;
  logic [1:0]                      operation;
  logic signed [OPERAND_WIDTH-1:0] a_numerator;
  logic signed [OPERAND_WIDTH-1:0] a_denominator;
  logic signed [OPERAND_WIDTH-1:0] b_numerator;
  logic signed [OPERAND_WIDTH-1:0] b_denominator;

  modport source (
    output valid, operation, a_numerator, a_denominator, b_numerator, b_denominator,
    input  ready
  );

  modport sink (
    input  valid, operation, a_numerator, a_denominator, b_numerator, b_denominator,
    output ready
  );

endinterface

### hw/rtl/rau_out_if.sv
// ----------------------------------------------------------------------------
// rau_out_if
// result channel: reduced fraction and error flag
// ----------------------------------------------------------------------------
interface rau_out_if;
  import rau_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [NUM_W-1:0] result_numerator;
  logic signed [DEN_W-1:0] result_denominator;
  logic                    error;

  modport source (
    output valid, result_numerator, result_denominator, error,
    input  ready
  );

  modport sink (
    input  valid, result_numerator, result_denominator, error,
    output ready
  );

endinterface

### hw/rtl/rau_div.sv
// ----------------------------------------------------------------------------
// rau_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rau_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rau_pkg::MAG_W-1:0]   dividend_i,
  input  logic [rau_pkg::MAG_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [rau_pkg::MAG_W-1:0]   quotient_o
);
  import rau_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [MAG_W-1:0] rem_q, rem_d;
  logic [MAG_W-1:0] quo_q, quo_d;
  logic [MAG_W-1:0] dsr_q, dsr_d;
  logic [MAG_W:0]   shifted;
  logic [MAG_W:0]   diff;

  always_comb begin
    shifted = {rem_q, quo_q[MAG_W-1]};
    diff    = shifted - {1'b0, dsr_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dsr_d   = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(MAG_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[MAG_W]) begin
        rem_d = diff[MAG_W-1:0];
        quo_d = {quo_q[MAG_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[MAG_W-1:0];
        quo_d = {quo_q[MAG_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### hw/rtl/rau_datapath.sv
// ----------------------------------------------------------------------------
// rau_datapath
// operand registers, shared multiplier, adder, binary gcd, divider and result registers
// ----------------------------------------------------------------------------
module rau_datapath (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  rau_pkg::cmd_e                           cmd_i,
  output rau_pkg::dp_status_t                     status_o,
  input  logic [1:0]                              operation_i,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] a_numerator_i,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] a_denominator_i,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] b_numerator_i,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] b_denominator_i,
  output logic signed [rau_pkg::NUM_W-1:0]         result_numerator_o,
  output logic signed [rau_pkg::DEN_W-1:0]         result_denominator_o,
  output logic                                    error_o
);
  import rau_pkg::*;

  localparam int unsigned OW    = OPERAND_WIDTH;
  localparam int unsigned NEXT_W = (MAG_W + 1 > NUM_W) ? MAG_W + 1 : NUM_W;
  localparam int unsigned DEXT_W = (MAG_W + 1 > DEN_W) ? MAG_W + 1 : DEN_W;

  op_e              op_q;
  logic             an_s_q, ad_s_q, bn_s_q, bd_s_q;
  logic [OW-1:0]    an_m_q, ad_m_q, bn_m_q, bd_m_q;
  logic             p_neg_q, q_neg_q, num_neg_q, den_neg_q;
  logic [MAG_W-1:0] p_mag_q, q_mag_q, num_mag_q, den_mag_q;
  logic [MAG_W-1:0] x_q, y_q, g_q;
  logic [CNT_W-1:0] k_q;
  logic signed [NUM_W-1:0] res_num_q;
  logic signed [DEN_W-1:0] res_den_q;
  logic                    res_err_q;

  logic             mul_sa, mul_sb;
  logic [OW-1:0]    mul_a, mul_b;
  logic [MAG_W-1:0] prod;
  logic             prod_neg;
  logic             sum_neg;
  logic [MAG_W-1:0] sum_mag;
  logic [MAG_W-1:0] x_d, y_d, g_comb;
  logic [CNT_W-1:0] k_d;
  logic             den_zero, gcd_done;
  logic             div_start, div_done;
  logic [MAG_W-1:0] div_dividend, div_divisor, div_quo;
  logic [NEXT_W-1:0] num_ext;
  logic [DEXT_W-1:0] den_ext;

  function automatic logic [OW-1:0] mag_of(logic [OW-1:0] v);
    return v[OW-1] ? (~v + OW'(1)) : v;
  endfunction

  // shared multiplier operand select
  always_comb begin
    mul_sa = ad_s_q;
    mul_a  = ad_m_q;
    mul_sb = bn_s_q;
    mul_b  = bn_m_q;
    case (cmd_i)
      CMD_MUL_P: begin
        mul_sa = an_s_q;
        mul_a  = an_m_q;
        mul_sb = (op_q == OP_MUL) ? bn_s_q : bd_s_q;
        mul_b  = (op_q == OP_MUL) ? bn_m_q : bd_m_q;
      end
      CMD_MUL_D: begin
        mul_sb = (op_q == OP_DIV) ? bn_s_q : bd_s_q;
        mul_b  = (op_q == OP_DIV) ? bn_m_q : bd_m_q;
      end
      default: begin
      end
    endcase
  end

  assign prod     = MAG_W'(mul_a) * MAG_W'(mul_b);
  assign prod_neg = (prod != '0) && (mul_sa ^ mul_sb);

  // signed magnitude add
  always_comb begin
    if (p_neg_q == q_neg_q) begin
      sum_mag = p_mag_q + q_mag_q;
      sum_neg = p_neg_q;
    end else if (p_mag_q >= q_mag_q) begin
      sum_mag = p_mag_q - q_mag_q;
      sum_neg = p_neg_q;
    end else begin
      sum_mag = q_mag_q - p_mag_q;
      sum_neg = q_neg_q;
    end
    if (sum_mag == '0) begin
      sum_neg = 1'b0;
    end
  end

  // binary gcd step
  assign gcd_done = (x_q == '0) || (y_q == '0);
  assign g_comb   = (x_q | y_q) << k_q;

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    k_d = k_q;
    if (!x_q[0] && !y_q[0]) begin
      x_d = x_q >> 1;
      y_d = y_q >> 1;
      k_d = k_q + CNT_W'(1);
    end else if (!x_q[0]) begin
      x_d = x_q >> 1;
    end else if (!y_q[0]) begin
      y_d = y_q >> 1;
    end else if (x_q >= y_q) begin
      x_d = (x_q - y_q) >> 1;
    end else begin
      y_d = (y_q - x_q) >> 1;
    end
  end

  assign den_zero     = (den_mag_q == '0);
  assign div_start    = (cmd_i == CMD_DIV_NUM) || (cmd_i == CMD_DIV_DEN);
  assign div_dividend = (cmd_i == CMD_DIV_NUM) ? num_mag_q : den_mag_q;
  assign div_divisor  = (cmd_i == CMD_DIV_NUM) ? g_comb : g_q;

  rau_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign num_ext = num_neg_q ? (~NEXT_W'(num_mag_q) + NEXT_W'(1)) : NEXT_W'(num_mag_q);
  assign den_ext = den_neg_q ? (~DEXT_W'(den_mag_q) + DEXT_W'(1)) : DEXT_W'(den_mag_q);

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        op_q   <= op_e'(operation_i);
        an_s_q <= a_numerator_i[OW-1];
        ad_s_q <= a_denominator_i[OW-1];
        bn_s_q <= b_numerator_i[OW-1];
        bd_s_q <= b_denominator_i[OW-1];
        an_m_q <= mag_of(a_numerator_i);
        ad_m_q <= mag_of(a_denominator_i);
        bn_m_q <= mag_of(b_numerator_i);
        bd_m_q <= mag_of(b_denominator_i);
      end
      CMD_MUL_P: begin
        p_mag_q <= prod;
        p_neg_q <= prod_neg;
      end
      CMD_MUL_Q: begin
        q_mag_q <= prod;
        q_neg_q <= prod_neg ^ ((prod != '0) && (op_q == OP_SUB));
      end
      CMD_MUL_D: begin
        den_mag_q <= prod;
        den_neg_q <= prod_neg;
      end
      CMD_SUM: begin
        if (op_q inside {OP_ADD, OP_SUB}) begin
          num_mag_q <= sum_mag;
          num_neg_q <= sum_neg;
        end else begin
          num_mag_q <= p_mag_q;
          num_neg_q <= p_neg_q;
        end
      end
      CMD_GCD_INIT: begin
        x_q <= num_mag_q;
        y_q <= den_mag_q;
        k_q <= '0;
      end
      CMD_GCD_STEP: begin
        x_q <= x_d;
        y_q <= y_d;
        k_q <= k_d;
      end
      CMD_DIV_NUM: begin
        g_q <= g_comb;
      end
      CMD_DIV_DEN: begin
        num_mag_q <= div_quo;
      end
      CMD_TAKE_DEN: begin
        den_mag_q <= div_quo;
      end
      CMD_OUT_LOAD: begin
        res_err_q <= den_zero;
        res_num_q <= den_zero ? '0 : num_ext[NUM_W-1:0];
        res_den_q <= den_zero ? '0 : den_ext[DEN_W-1:0];
      end
      default: begin
      end
    endcase
  end

  assign status_o.den_zero = den_zero;
  assign status_o.gcd_done = gcd_done;
  assign status_o.div_done = div_done;

  assign result_numerator_o   = res_num_q;
  assign result_denominator_o = res_den_q;
  assign error_o              = res_err_q;

endmodule

### hw/rtl/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl
// sequencer for the multiply, add, gcd and divide steps and both handshakes
// ----------------------------------------------------------------------------
module rau_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rau_pkg::cmd_e       cmd_o,
  input  rau_pkg::dp_status_t status_i
);
  import rau_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = CMD_NONE;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = ST_MUL_P;
        end
      end
      ST_MUL_P: begin
        cmd_o   = CMD_MUL_P;
        state_d = ST_MUL_Q;
      end
      ST_MUL_Q: begin
        cmd_o   = CMD_MUL_Q;
        state_d = ST_MUL_D;
      end
      ST_MUL_D: begin
        cmd_o   = CMD_MUL_D;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        cmd_o   = CMD_SUM;
        state_d = status_i.den_zero ? ST_OUT : ST_GCD_INIT;
      end
      ST_GCD_INIT: begin
        cmd_o   = CMD_GCD_INIT;
        state_d = ST_GCD;
      end
      ST_GCD: begin
        if (status_i.gcd_done) begin
          cmd_o   = CMD_DIV_NUM;
          state_d = ST_DIV_NUM;
        end else begin
          cmd_o = CMD_GCD_STEP;
        end
      end
      ST_DIV_NUM: begin
        if (status_i.div_done) begin
          cmd_o   = CMD_DIV_DEN;
          state_d = ST_DIV_DEN;
        end
      end
      ST_DIV_DEN: begin
        if (status_i.div_done) begin
          cmd_o   = CMD_TAKE_DEN;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o       = CMD_OUT_LOAD;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

### hw/rtl/rational_arith_unit.sv
// ----------------------------------------------------------------------------
// rational_arith_unit
// exact add, subtract, multiply and divide of two signed fractions, with the
// result reduced by the greatest common divisor
//
//   channel  dir  payload                                         transfer
//   in_i     in   operation, a/b numerator and denominator        valid & ready
//   out_o    out  result_numerator, result_denominator, error     valid & ready
//
// one item at a time: multiply and add, then the binary gcd loop, then the
// shared bit-serial divider for numerator and denominator; a zero
// denominator skips the gcd and the divider. the gcd loop and the divider
// set the time per item.
// reset clears the sequencer and the output valid; no clearing pass.
// a finished result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module rational_arith_unit (
  input  logic    clk_i,
  input  logic    rst_ni,
  rau_in_if.sink  in_i,
  rau_out_if.source out_o
);
  import rau_pkg::*;

  cmd_e       cmd;
  dp_status_t status;

  rau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  rau_datapath u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (status),
    .operation_i          (in_i.operation),
    .a_numerator_i        (in_i.a_numerator),
    .a_denominator_i      (in_i.a_denominator),
    .b_numerator_i        (in_i.b_numerator),
    .b_denominator_i      (in_i.b_denominator),
    .result_numerator_o   (out_o.result_numerator),
    .result_denominator_o (out_o.result_denominator),
    .error_o              (out_o.error)
  );

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks rational_arith_unit against a behavioral model of exact fraction
// add, subtract, multiply and divide with gcd reduction. directed items cover
// every operation, operand extremes and the zero numerator and denominator
// cases; random traffic follows with bursty input, stalled output, one long
// output hold-off and pauses that let the unit drain.
// ----------------------------------------------------------------------------
module testbench;
  import rau_pkg::*;

  typedef logic signed [OPERAND_WIDTH-1:0] operand_t;

  typedef struct {
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
    logic                    err;
  } fraction_result_t;

  typedef enum {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PATTERN
  } stall_mode_e;

  logic clk_i;
  logic rst_ni;

  rau_in_if  in_bus ();
  rau_out_if out_bus ();

  rational_arith_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  fraction_result_t pending_results[$];
  int unsigned      mismatch_count  = 0;
  int unsigned      results_checked = 0;
  int unsigned      items_sent      = 0;
  int unsigned      zero_den_items  = 0;
  int unsigned      burst_left      = 0;
  int unsigned      gap_max         = 0;
  int unsigned      hold_left       = 0;
  stall_mode_e      stall_mode      = STALL_NONE;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d results still pending", pending_results.size());
    $display("** rational_arith_unit: FAILED **");
    $finish;
  end

  function automatic fraction_result_t reduce_fraction(input op_e op, input operand_t an,
                                                       input operand_t ad, input operand_t bn,
                                                       input operand_t bd);
    longint n, d, x, y, t;
    fraction_result_t r;
    case (op)
      OP_ADD: begin
        n = longint'(an) * longint'(bd) + longint'(ad) * longint'(bn);
        d = longint'(ad) * longint'(bd);
      end
      OP_SUB: begin
        n = longint'(an) * longint'(bd) - longint'(ad) * longint'(bn);
        d = longint'(ad) * longint'(bd);
      end
      OP_MUL: begin
        n = longint'(an) * longint'(bn);
        d = longint'(ad) * longint'(bd);
      end
      default: begin
        n = longint'(an) * longint'(bd);
        d = longint'(ad) * longint'(bn);
      end
    endcase
    if (d == 0) begin
      r.num = '0;
      r.den = '0;
      r.err = 1'b1;
      return r;
    end
    // euclid on magnitudes; a zero numerator leaves |d| as the divisor
    x = (n < 0) ? -n : n;
    y = (d < 0) ? -d : d;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    r.num = NUM_W'(n / x);
    r.den = DEN_W'(d / x);
    r.err = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 50) begin
      $display("mismatch at result %0d: %s", results_checked, msg);
    end
  endtask

  task automatic send_fraction_op(input op_e op, input operand_t an, input operand_t ad,
                                  input operand_t bn, input operand_t bd);
    int unsigned      gap;
    fraction_result_t want;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, 8);
      if (gap != 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_bus.valid         <= 1'b1;
    in_bus.operation     <= op;
    in_bus.a_numerator   <= an;
    in_bus.a_denominator <= ad;
    in_bus.b_numerator   <= bn;
    in_bus.b_denominator <= bd;
    @(negedge clk_i);
    while (!in_bus.ready) @(negedge clk_i);
    @(posedge clk_i);
    want = reduce_fraction(op, an, ad, bn, bd);
    pending_results.push_back(want);
    items_sent++;
    if (want.err) zero_den_items++;
  endtask

  task automatic wait_for_results();
    in_bus.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic operand_t pick_operand();
    int small_val;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0:       return operand_t'(0);
          1:       return operand_t'(1);
          2:       return operand_t'(-1);
          3:       return operand_t'(32767);
          default: return operand_t'(-32768);
        endcase
      end
      1, 2: begin
        small_val = int'($urandom_range(0, 40)) - 20;
        return operand_t'(small_val);
      end
      default: return operand_t'($urandom);
    endcase
  endfunction

  task automatic test_basic_operations();
    send_fraction_op(OP_ADD, 1, 2, 1, 3);
    send_fraction_op(OP_SUB, 1, 2, 1, 3);
    send_fraction_op(OP_MUL, 2, 3, 3, 4);
    send_fraction_op(OP_DIV, 1, 2, 3, 4);
    send_fraction_op(OP_SUB, 1, 3, 1, 2);
    send_fraction_op(OP_DIV, -1, -1, -1, -1);
    wait_for_results();
  endtask

  task automatic test_zero_cases();
    send_fraction_op(OP_ADD, 3, 0, 1, 5);
    send_fraction_op(OP_MUL, 3, 7, 1, 0);
    send_fraction_op(OP_DIV, 3, 7, 0, 5);
    send_fraction_op(OP_SUB, 0, 0, 0, 0);
    send_fraction_op(OP_MUL, 0, 5, 3, 7);
    send_fraction_op(OP_MUL, 0, -5, 3, 7);
    send_fraction_op(OP_SUB, 1, 2, 1, 2);
    send_fraction_op(OP_ADD, 1, -2, 1, 2);
    wait_for_results();
  endtask

  task automatic test_operand_extremes();
    send_fraction_op(OP_ADD, -32768, 32767, -32768, 32767);
    send_fraction_op(OP_MUL, 32767, -32768, 32767, -32768);
    send_fraction_op(OP_DIV, -32768, 1, 1, -32768);
    send_fraction_op(OP_ADD, -32768, -32768, -32768, -32768);
    send_fraction_op(OP_SUB, -32768, -32768, 32767, -32768);
    send_fraction_op(OP_ADD, -32768, 32767, -32767, -32768);
    send_fraction_op(OP_SUB, 32767, 1, -32768, 1);
    send_fraction_op(OP_DIV, 32767, -32768, -32768, 32767);
    wait_for_results();
  endtask

  task automatic test_output_hold_off();
    stall_mode = STALL_NONE;
    gap_max    = 0;
    hold_left  = 700;
    repeat (8) send_fraction_op(op_e'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                                pick_operand(), pick_operand());
    wait_for_results();
  endtask

  task automatic test_random_traffic(input stall_mode_e mode, input int unsigned gaps,
                                     input int unsigned count);
    stall_mode = mode;
    gap_max    = gaps;
    repeat (count) begin
      send_fraction_op(op_e'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                       pick_operand(), pick_operand());
      if ($urandom_range(0, 99) == 0) wait_for_results();
    end
    wait_for_results();
  endtask

  initial begin : result_receiver
    logic [15:0] rotor;
    out_bus.ready <= 1'b0;
    rotor = 16'hf1b3;
    forever begin
      @(posedge clk_i);
      rotor = {rotor[14:0], rotor[15]};
      if (hold_left != 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        case (stall_mode)
          STALL_NONE:   out_bus.ready <= 1'b1;
          STALL_RANDOM: out_bus.ready <= ($urandom_range(0, 3) != 0);
          default:      out_bus.ready <= rotor[0];
        endcase
      end
    end
  end

  initial begin : result_checker
    fraction_result_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_bus.valid && out_bus.ready) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with no operation pending");
        end else begin
          want = pending_results.pop_front();
          if (out_bus.result_numerator !== want.num) begin
            report_mismatch($sformatf("numerator %0d, expected %0d",
                                      out_bus.result_numerator, want.num));
          end
          if (out_bus.result_denominator !== want.den) begin
            report_mismatch($sformatf("denominator %0d, expected %0d",
                                      out_bus.result_denominator, want.den));
          end
          if (out_bus.error !== want.err) begin
            report_mismatch($sformatf("error %b, expected %b", out_bus.error, want.err));
          end
        end
      end
    end
  end

  initial begin
    rst_ni               <= 1'b0;
    in_bus.valid         <= 1'b0;
    in_bus.operation     <= OP_ADD;
    in_bus.a_numerator   <= '0;
    in_bus.a_denominator <= '0;
    in_bus.b_numerator   <= '0;
    in_bus.b_denominator <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    stall_mode = STALL_RANDOM;
    gap_max    = 3;
    test_basic_operations();
    test_zero_cases();
    test_operand_extremes();
    test_output_hold_off();
    test_random_traffic(STALL_NONE, 0, 300);
    test_random_traffic(STALL_RANDOM, 6, 450);
    test_random_traffic(STALL_PATTERN, 40, 350);
    test_random_traffic(STALL_RANDOM, 200, 150);
    test_random_traffic(STALL_PATTERN, 3, 450);

    wait_for_results();
    repeat (300) @(posedge clk_i);
    $display("ran %0d operations on all four codes, %0d with a zero denominator, %0d results",
             items_sent, zero_den_items, results_checked);
    $display("traffic: input bursts and gaps, random and patterned output stalls, long hold-off");
    if (mismatch_count == 0) begin
      $display("** rational_arith_unit: PASSED **");
    end else begin
      $display("** rational_arith_unit: FAILED **");
    end
    $finish;
  end

endmodule
